// ===== rtl/uv_sphere_vertex_index_gen_assert.svh =====
// ----------------------------------------------------------------------------
// UV sphere generator assertion macros
// Shared assertion forms for the sphere generator; they expect the clock
// and reset of the module that uses them to be named clock and reset.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_INDEX_GEN_ASSERT_SVH
`define UV_SPHERE_VERTEX_INDEX_GEN_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UVS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define UVS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define UVS_ASSERT_IMP(label, ante, cons, msg)
`define UVS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/uvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere generator package
// Shared widths, constants and the arctangent table of the rotation unit.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int CSR_W     = 9;
   localparam int IDX_W     = 17;
   localparam int POS_W     = 16;
   localparam int WORK_W    = 32;
   localparam int WORK_FRAC = 30;
   localparam int RES_MIN   = 3;
   localparam int RES_RESET = 16;

   localparam logic signed [WORK_W-1:0] CORDIC_INIT_X = 32'sh26DD3B6A;
   localparam logic signed [WORK_W-1:0] ONE_Q30       = 32'sh40000000;

   localparam logic [31:0] ATAN_TURNS [0:31] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_1,
      QUAD_2,
      QUAD_3
   } quad_type;

endpackage
`default_nettype wire

// ===== rtl/uv_sphere_vertex_index_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "uv_sphere_vertex_index_gen_assert.svh"
// ----------------------------------------------------------------------------
// UV sphere vertex and index generator
// Each request beat produces the next sphere vertex position and the corner
// indices of the quad it closes, walking the rings from pole to pole.
// ----------------------------------------------------------------------------
// Usage: the csr channel writes the resolution (clamped to 3..MAX_RES); a
// write also returns the walk to the bottom pole. After reset and after each
// write the angle step divider runs, and req_stall is high while it does. A
// request beat with req_restart set emits vertex 0 and continues from there;
// otherwise it emits the current vertex and advances. One response beat
// follows each request beat, and the next request beat can be taken as soon
// as the response is valid. The single CORDIC unit computes the elevation and
// then the azimuth sine and cosine one step per cycle, followed by two passes
// through one multiplier. Angles on a quadrant boundary skip the CORDIC steps.
// The block takes one vertex at a time; a new request is accepted while the
// previous response still waits in the output register. When rsp_stall is
// high the response holds and the next vertex waits in its last state.
// Synchronous reset clears the walk and sets the resolution to 16.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_index_gen #(
   parameter int MAX_RES         = 256,
   parameter int COORD_FRAC_BITS = 14,
   parameter int ANGLE_BITS      = 16,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [uvs_pkg::CSR_W-1:0]          csr_resolution,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [uvs_pkg::POS_W-1:0]   rsp_pos_x,
   output logic signed [uvs_pkg::POS_W-1:0]   rsp_pos_y,
   output logic signed [uvs_pkg::POS_W-1:0]   rsp_pos_z,
   output logic [uvs_pkg::IDX_W-1:0]          rsp_vertex_index,
   output logic [uvs_pkg::IDX_W-1:0]          rsp_corner_bottom_left,
   output logic [uvs_pkg::IDX_W-1:0]          rsp_corner_bottom_right,
   output logic [uvs_pkg::IDX_W-1:0]          rsp_corner_top_right,
   output logic                               rsp_triangles_valid,
   output logic                               rsp_last_vertex
);
   import uvs_pkg::*;

   localparam int COL_W  = $clog2(MAX_RES);
   localparam int RING_W = $clog2(MAX_RES + 1);
   localparam int CMP_W  = (RING_W > CSR_W) ? RING_W : CSR_W;
   localparam int PROD_SHIFT = 2 * WORK_FRAC - COORD_FRAC_BITS;
   localparam int SE_SHIFT   = WORK_FRAC - COORD_FRAC_BITS;
   localparam logic [ANGLE_BITS-1:0] ELEV_INIT = {2'b11, {(ANGLE_BITS - 2){1'b0}}};
   localparam logic signed [64:0] COORD_LIM = 65'sd1 <<< COORD_FRAC_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EL,
      S_AZ,
      S_MX,
      S_MZ,
      S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [CSR_W-1:0]      res_ff, res_in;
   logic [RING_W-1:0]     ring_ff, ring_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [IDX_W-1:0]      vc_ff, vc_in;
   logic [ANGLE_BITS-1:0] az_ff, az_in, el_ff, el_in;
   logic [CSR_W-1:0]      az_r_ff, az_r_in, el_r_ff, el_r_in;
   logic                  cor_start_ff, cor_start_in;
   logic                  div_start_ff, div_start_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic signed [WORK_W-1:0] ce_ff, ce_in, se_ff, se_in;
   logic signed [WORK_W-1:0] ca_ff, ca_in, sa_ff, sa_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic [POS_W-1:0]         px_ff, px_in;
   logic [POS_W-1:0]         pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic [IDX_W-1:0]         vi_ff, vi_in, bl_ff, bl_in, br_ff, br_in, tr_ff, tr_in;
   logic                     tv_ff, tv_in, last_ff, last_in;

   logic                     div_busy;
   logic [ANGLE_BITS-1:0]    div_az_q, div_el_q;
   logic [CSR_W-1:0]         div_az_r, div_el_r;
   logic                     cor_done;
   logic signed [WORK_W-1:0] cor_cos, cor_sin, mul_b;
   logic [ANGLE_BITS-1:0]    cor_angle;

   logic                     req_take, gen_clear, col_wrap, is_last;
   logic [IDX_W-1:0]         next_col, res_idx, row_base, tr_idx;
   logic [CSR_W:0]           r_sum;
   logic                     r_carry;

   function automatic logic [POS_W-1:0] sat_pos(input logic signed [64:0] v);
      logic signed [64:0] s;
      s = v;
      if (s > COORD_LIM) begin
         s = COORD_LIM;
      end else if (s < -COORD_LIM) begin
         s = -COORD_LIM;
      end
      return s[POS_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] round_prod(input logic signed [63:0] v);
      logic signed [64:0] w;
      w = $signed({v, 1'b0}) + (65'sd1 <<< PROD_SHIFT);
      return sat_pos(w >>> (PROD_SHIFT + 1));
   endfunction

   function automatic logic [POS_W-1:0] round_se(input logic signed [WORK_W-1:0] v);
      logic signed [64:0] w;
      w = $signed({{(64 - WORK_W){v[WORK_W-1]}}, v, 1'b0}) + (65'sd1 <<< SE_SHIFT);
      return sat_pos(w >>> (SE_SHIFT + 1));
   endfunction

   uvs_step_div #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_step_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start_ff),
      .divisor (res_ff),
      .busy    (div_busy),
      .az_q    (div_az_q),
      .az_r    (div_az_r),
      .el_q    (div_el_q),
      .el_r    (div_el_r)
   );

   assign cor_angle = (state_ff == S_EL) ? el_ff : az_ff;

   uvs_cordic #(
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start_ff),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   assign csr_ready = (state_ff == S_IDLE);
   assign req_stall = !((state_ff == S_IDLE) && !csr_valid && !div_start_ff && !div_busy);
   assign req_take  = req_valid && !req_stall;
   assign mul_b     = (state_ff == S_MZ) ? sa_ff : ca_ff;

   always_comb begin
      col_wrap = (CMP_W'(col_ff) + CMP_W'(1)) >= CMP_W'(res_ff);
      is_last  = (CMP_W'(ring_ff) >= CMP_W'(res_ff)) && col_wrap;
      next_col = col_wrap ? '0 : IDX_W'(col_ff) + IDX_W'(1);
      res_idx  = IDX_W'(res_ff);
      row_base = vc_ff - IDX_W'(col_ff);
      tr_idx   = row_base + next_col;
      r_sum    = '0;
      r_carry  = 1'b0;

      state_in     = state_ff;
      res_in       = res_ff;
      ring_in      = ring_ff;
      col_in       = col_ff;
      vc_in        = vc_ff;
      az_in        = az_ff;
      az_r_in      = az_r_ff;
      el_in        = el_ff;
      el_r_in      = el_r_ff;
      cor_start_in = 1'b0;
      div_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      gen_clear    = 1'b0;
      ce_in        = ce_ff;
      se_in        = se_ff;
      ca_in        = ca_ff;
      sa_in        = sa_ff;
      prod_in      = prod_ff;
      px_in        = px_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      vi_in        = vi_ff;
      bl_in        = bl_ff;
      br_in        = br_ff;
      tr_in        = tr_ff;
      tv_in        = tv_ff;
      last_in      = last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_resolution < CSR_W'(RES_MIN)) begin
                  res_in = CSR_W'(RES_MIN);
               end else if (CMP_W'(csr_resolution) > CMP_W'(MAX_RES)) begin
                  res_in = CSR_W'(MAX_RES);
               end else begin
                  res_in = csr_resolution;
               end
               div_start_in = 1'b1;
               gen_clear    = 1'b1;
            end else if (req_take) begin
               gen_clear    = req_restart;
               cor_start_in = 1'b1;
               state_in     = S_EL;
            end
         end
         S_EL: begin
            if (cor_done) begin
               ce_in        = cor_cos;
               se_in        = cor_sin;
               cor_start_in = 1'b1;
               state_in     = S_AZ;
            end
         end
         S_AZ: begin
            if (cor_done) begin
               ca_in    = cor_cos;
               sa_in    = cor_sin;
               state_in = S_MX;
            end
         end
         S_MX: begin
            prod_in  = ce_ff * mul_b;
            state_in = S_MZ;
         end
         S_MZ: begin
            px_in    = round_prod(prod_ff);
            prod_in  = ce_ff * mul_b;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               pos_x_in     = px_ff;
               pos_y_in     = round_se(se_ff);
               pos_z_in     = round_prod(prod_ff);
               vi_in        = vc_ff;
               last_in      = is_last;
               if (ring_ff != '0) begin
                  bl_in = vc_ff - res_idx;
                  br_in = tr_idx - res_idx;
                  tr_in = tr_idx;
                  tv_in = 1'b1;
               end else begin
                  bl_in = '0;
                  br_in = '0;
                  tr_in = '0;
                  tv_in = 1'b0;
               end
               if (is_last) begin
                  gen_clear = 1'b1;
               end else if (col_wrap) begin
                  col_in  = '0;
                  az_in   = '0;
                  az_r_in = '0;
                  ring_in = ring_ff + RING_W'(1);
                  vc_in   = vc_ff + IDX_W'(1);
                  r_sum   = {1'b0, el_r_ff} + {1'b0, div_el_r};
                  r_carry = r_sum >= {1'b0, res_ff};
                  el_r_in = r_carry ? CSR_W'(r_sum - {1'b0, res_ff}) : r_sum[CSR_W-1:0];
                  el_in   = el_ff + div_el_q + ANGLE_BITS'(r_carry);
               end else begin
                  col_in  = col_ff + COL_W'(1);
                  vc_in   = vc_ff + IDX_W'(1);
                  r_sum   = {1'b0, az_r_ff} + {1'b0, div_az_r};
                  r_carry = r_sum >= {1'b0, res_ff};
                  az_r_in = r_carry ? CSR_W'(r_sum - {1'b0, res_ff}) : r_sum[CSR_W-1:0];
                  az_in   = az_ff + div_az_q + ANGLE_BITS'(r_carry);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (gen_clear) begin
         ring_in = '0;
         col_in  = '0;
         vc_in   = '0;
         az_in   = '0;
         az_r_in = '0;
         el_in   = ELEV_INIT;
         el_r_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_ff       <= CSR_W'(RES_RESET);
         ring_ff      <= '0;
         col_ff       <= '0;
         vc_ff        <= '0;
         az_ff        <= '0;
         az_r_ff      <= '0;
         el_ff        <= ELEV_INIT;
         el_r_ff      <= '0;
         cor_start_ff <= 1'b0;
         div_start_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_ff       <= res_in;
         ring_ff      <= ring_in;
         col_ff       <= col_in;
         vc_ff        <= vc_in;
         az_ff        <= az_in;
         az_r_ff      <= az_r_in;
         el_ff        <= el_in;
         el_r_ff      <= el_r_in;
         cor_start_ff <= cor_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ce_ff    <= ce_in;
      se_ff    <= se_in;
      ca_ff    <= ca_in;
      sa_ff    <= sa_in;
      prod_ff  <= prod_in;
      px_ff    <= px_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      pos_z_ff <= pos_z_in;
      vi_ff    <= vi_in;
      bl_ff    <= bl_in;
      br_ff    <= br_in;
      tr_ff    <= tr_in;
      tv_ff    <= tv_in;
      last_ff  <= last_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_pos_x               = pos_x_ff;
   assign rsp_pos_y               = pos_y_ff;
   assign rsp_pos_z               = pos_z_ff;
   assign rsp_vertex_index        = vi_ff;
   assign rsp_corner_bottom_left  = bl_ff;
   assign rsp_corner_bottom_right = br_ff;
   assign rsp_corner_top_right    = tr_ff;
   assign rsp_triangles_valid     = tv_ff;
   assign rsp_last_vertex         = last_ff;

   `UVS_ASSERT_IMP(a_col_in_range, 1'b1, CMP_W'(col_ff) < CMP_W'(res_ff),
                   "Column count reached the resolution")
   `UVS_ASSERT_IMP(a_ring_in_range, 1'b1, CMP_W'(ring_ff) <= CMP_W'(res_ff),
                   "Ring count passed the top pole")
   `UVS_ASSERT_NXT(a_accept_starts, req_valid && !req_stall, state_ff == S_EL,
                   "Accepted beat did not start the elevation pass")
   `UVS_ASSERT_IMP(a_last_has_quad, rsp_valid_ff && last_ff, tv_ff,
                   "Last vertex reported without a quad")

endmodule
`default_nettype wire

// ===== rtl/uvs_step_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UV sphere angle step divider
// Restoring divider, one quotient bit per cycle, that splits a full turn and
// a half turn by the resolution into whole steps and remainders.
// ----------------------------------------------------------------------------
module uvs_step_div #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [uvs_pkg::CSR_W-1:0]    divisor,
   output logic                         busy,
   output logic [ANGLE_BITS-1:0]        az_q,
   output logic [uvs_pkg::CSR_W-1:0]    az_r,
   output logic [ANGLE_BITS-1:0]        el_q,
   output logic [uvs_pkg::CSR_W-1:0]    el_r
);
   import uvs_pkg::*;

   localparam int CNT_W = $clog2(ANGLE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CSR_W-1:0]      rem_ff, rem_in;
   logic [ANGLE_BITS-1:0] quot_ff, quot_in;
   logic [ANGLE_BITS-1:0] az_q_ff, az_q_in, el_q_ff, el_q_in;
   logic [CSR_W-1:0]      az_r_ff, az_r_in, el_r_ff, el_r_in;
   logic [CSR_W:0]        trial;
   logic                  ge;

   always_comb begin
      trial = {rem_ff, (cnt_ff == CNT_W'(ANGLE_BITS))};
      ge    = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      az_q_in = az_q_ff;
      az_r_in = az_r_ff;
      el_q_in = el_q_ff;
      el_r_in = el_r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ANGLE_BITS);
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? CSR_W'(trial - {1'b0, divisor}) : trial[CSR_W-1:0];
         quot_in = {quot_ff[ANGLE_BITS-2:0], ge};
         if (cnt_ff == CNT_W'(1)) begin
            el_q_in = quot_in;
            el_r_in = rem_in;
         end
         if (cnt_ff == '0) begin
            az_q_in = quot_in;
            az_r_in = rem_in;
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      az_q_ff <= az_q_in;
      az_r_ff <= az_r_in;
      el_q_ff <= el_q_in;
      el_r_ff <= el_r_in;
   end

   assign busy = busy_ff;
   assign az_q = az_q_ff;
   assign az_r = az_r_ff;
   assign el_q = el_q_ff;
   assign el_r = el_r_ff;

endmodule
`default_nettype wire

// ===== rtl/uvs_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "uv_sphere_vertex_index_gen_assert.svh"
// ----------------------------------------------------------------------------
// UV sphere sine and cosine unit
// Iterative rotation CORDIC, one step per cycle, on a turn angle reduced to
// one quadrant; the quadrant is folded back in on the outputs.
// ----------------------------------------------------------------------------
module uvs_cordic #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ANGLE_BITS-1:0]               angle,
   output logic                                done,
   output logic signed [uvs_pkg::WORK_W-1:0]   cos_out,
   output logic signed [uvs_pkg::WORK_W-1:0]   sin_out
);
   import uvs_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_W-1:0]        cnt_ff, cnt_in;
   logic signed [WORK_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0]               quad_ff, quad_in;
   logic [31:0]              a_word;
   logic signed [WORK_W-1:0] dx, dy, at;

   always_comb begin
      a_word  = 32'(angle) << (32 - ANGLE_BITS);
      dx      = y_ff >>> cnt_ff;
      dy      = x_ff >>> cnt_ff;
      at      = $signed(ATAN_TURNS[5'(cnt_ff)]);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      if (start) begin
         quad_in = a_word[31:30];
         y_in    = '0;
         cnt_in  = '0;
         z_in    = WORK_W'($signed({2'b00, a_word[29:0]}));
         if (a_word[29:0] == '0) begin
            x_in    = ONE_Q30;
            done_in = 1'b1;
         end else begin
            x_in    = CORDIC_INIT_X;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + STEP_W'(1);
         end
      end
   end

   always_comb begin
      case (quad_type'(quad_ff))
         QUAD_1: begin
            cos_out = -y_ff;
            sin_out = x_ff;
         end
         QUAD_2: begin
            cos_out = -x_ff;
            sin_out = -y_ff;
         end
         QUAD_3: begin
            cos_out = y_ff;
            sin_out = -x_ff;
         end
         default: begin
            cos_out = x_ff;
            sin_out = y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
   end

   assign done = done_ff;

   `UVS_ASSERT_IMP(a_no_start_while_busy, start, !busy_ff, "CORDIC started while busy")
   `UVS_ASSERT_NXT(a_done_single, done_ff, !done_ff, "CORDIC done held over two cycles")
   `UVS_ASSERT_IMP(a_step_in_range, busy_ff, cnt_ff <= STEP_W'(CORDIC_STEPS - 1),
                   "CORDIC step count past the last step")

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere vertex and index generator testbench
// A table of directed beats and resolution writes covers the poles, the
// clamped resolutions, restart and the wrap after the last vertex. Random
// phases at several resolutions follow. Every response beat is compared
// field by field with the expected vertex of its directed row or else with a
// bit-exact predictor of the angle walk, the rotation unit and the index
// arithmetic, under bursty requests and stalled responses.
// ----------------------------------------------------------------------------
module testbench;
   import uvs_pkg::*;

   localparam int ROTATION_STEPS = 16;
   localparam int VERTEX_LATENCY = 2 * ROTATION_STEPS + 8;
   localparam int PHASE_BEATS    = 140;
   localparam int PHASE_COUNT    = 10;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [IDX_W-1:0]        vertex_index;
      logic [IDX_W-1:0]        corner_bottom_left;
      logic [IDX_W-1:0]        corner_bottom_right;
      logic [IDX_W-1:0]        corner_top_right;
      logic                    triangles_valid;
      logic                    last_vertex;
   } vertex_type;

   typedef struct packed {
      logic       restart;
      logic       typed;
      vertex_type exp;
   } beat_type;

   typedef enum logic {STIM_BEAT, STIM_CSR} stim_kind_type;

   typedef struct packed {
      stim_kind_type    kind;
      logic [CSR_W-1:0] value;
      logic             typed;
      vertex_type       exp;
   } stim_row_type;

   localparam vertex_type NO_VERTEX = '0;
   localparam vertex_type BOTTOM_POLE = '{16'sd0, -16'sd16384, 16'sd0,
                                          17'd0, 17'd0, 17'd0, 17'd0, 1'b0, 1'b0};
   localparam vertex_type TOP_POLE_RES3 = '{16'sd0, 16'sd16384, 16'sd0,
                                            17'd11, 17'd8, 17'd6, 17'd9, 1'b1, 1'b1};

   localparam stim_row_type DIRECTED [0:24] = '{
      '{STIM_BEAT, 9'd0,   1'b1, BOTTOM_POLE},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd1,   1'b1, BOTTOM_POLE},
      '{STIM_CSR,  9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b1, BOTTOM_POLE},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b1, TOP_POLE_RES3},
      '{STIM_BEAT, 9'd0,   1'b1, BOTTOM_POLE},
      '{STIM_CSR,  9'd511, 1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd0,   1'b1, BOTTOM_POLE},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd1,   1'b1, BOTTOM_POLE},
      '{STIM_CSR,  9'd2,   1'b0, NO_VERTEX},
      '{STIM_BEAT, 9'd1,   1'b1, BOTTOM_POLE},
      '{STIM_BEAT, 9'd0,   1'b0, NO_VERTEX}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_resolution = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_y;
   logic signed [POS_W-1:0] rsp_pos_z;
   logic [IDX_W-1:0] rsp_vertex_index;
   logic [IDX_W-1:0] rsp_corner_bottom_left;
   logic [IDX_W-1:0] rsp_corner_bottom_right;
   logic [IDX_W-1:0] rsp_corner_top_right;
   logic rsp_triangles_valid;
   logic rsp_last_vertex;

   uv_sphere_vertex_index_gen dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_resolution          (csr_resolution),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_restart             (req_restart),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_pos_x               (rsp_pos_x),
      .rsp_pos_y               (rsp_pos_y),
      .rsp_pos_z               (rsp_pos_z),
      .rsp_vertex_index        (rsp_vertex_index),
      .rsp_corner_bottom_left  (rsp_corner_bottom_left),
      .rsp_corner_bottom_right (rsp_corner_bottom_right),
      .rsp_corner_top_right    (rsp_corner_top_right),
      .rsp_triangles_valid     (rsp_triangles_valid),
      .rsp_last_vertex         (rsp_last_vertex)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Walk state of the sphere predictor.
   logic [CSR_W-1:0]  resolution_q;
   logic [8:0]        ring_q;
   logic [7:0]        column_q;
   logic [IDX_W-1:0]  vertex_count_q;
   logic [15:0]       azim_phase_q;
   logic [8:0]        azim_rem_q;
   logic [15:0]       elev_phase_q;
   logic [8:0]        elev_rem_q;

   beat_type   beat_q [$];
   vertex_type vertex_q [$];
   int         mismatches = 0;

   int          burst_left = 1;
   int          gap_left = 0;
   bit          quiet_sender = 1'b0;
   logic [15:0] stall_pattern = '0;
   logic [3:0]  stall_pos = '0;
   beat_type    sent_beat;
   vertex_type  predicted;
   vertex_type  observed;
   vertex_type  awaited;

   function automatic void restart_walk();
      ring_q         = '0;
      column_q       = '0;
      vertex_count_q = '0;
      azim_phase_q   = '0;
      azim_rem_q     = '0;
      elev_phase_q   = 16'hC000;
      elev_rem_q     = '0;
   endfunction

   function automatic void apply_resolution(input logic [CSR_W-1:0] value);
      int v;
      v = value;
      if (v < RES_MIN) v = RES_MIN;
      if (v > 256) v = 256;
      resolution_q = CSR_W'(v);
      restart_walk();
   endfunction

   function automatic void queue_beat(input logic restart, input logic typed,
                                      input vertex_type exp);
      beat_type b;
      b.restart = restart;
      b.typed   = typed;
      b.exp     = exp;
      beat_q.insert(beat_q.size(), b);
   endfunction

   // Sine and cosine of a 16-bit turn fraction, both in Q2.30.
   function automatic void sin_cos_q30(input logic [15:0] angle, output longint c,
                                       output longint s);
      logic [31:0] turn;
      logic [29:0] residue;
      longint x, y, z, dx, dy, t;
      int i;
      turn    = {angle, 16'h0000};
      residue = turn[29:0];
      x = longint'(ONE_Q30);
      y = 0;
      if (residue != 0) begin
         x = longint'(CORDIC_INIT_X);
         z = longint'({34'd0, residue});
         for (i = 0; i < ROTATION_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - longint'({32'd0, ATAN_TURNS[i]});
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + longint'({32'd0, ATAN_TURNS[i]});
            end
         end
      end
      case (quad_type'(turn[31:30]))
         QUAD_1: begin
            t = x;
            x = -y;
            y = t;
         end
         QUAD_2: begin
            x = -x;
            y = -y;
         end
         QUAD_3: begin
            t = x;
            x = y;
            y = -t;
         end
         default: ;
      endcase
      c = x;
      s = y;
   endfunction

   function automatic logic signed [POS_W-1:0] to_coord(input longint v, input int shift);
      longint r;
      longint lim;
      lim = longint'(1) <<< 14;
      r = (v + (longint'(1) <<< (shift - 1))) >>> shift;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return POS_W'(r);
   endfunction

   function automatic vertex_type next_vertex(input logic restart);
      vertex_type v;
      longint ce, se, ca, sa;
      int n, row, col, nxt, r;
      bit wrap_mesh;
      n = resolution_q;
      if (restart) restart_walk();
      row = ring_q;
      col = column_q;
      sin_cos_q30(elev_phase_q, ce, se);
      sin_cos_q30(azim_phase_q, ca, sa);
      v.pos_x = to_coord(ce * ca, 2 * WORK_FRAC - 14);
      v.pos_y = to_coord(se, WORK_FRAC - 14);
      v.pos_z = to_coord(ce * sa, 2 * WORK_FRAC - 14);
      v.vertex_index = vertex_count_q;
      nxt = (col + 1 >= n) ? 0 : col + 1;
      if (row != 0) begin
         v.corner_bottom_left  = IDX_W'(int'(vertex_count_q) - n);
         v.corner_bottom_right = IDX_W'((row - 1) * n + nxt);
         v.corner_top_right    = IDX_W'(row * n + nxt);
         v.triangles_valid     = 1'b1;
      end else begin
         v.corner_bottom_left  = '0;
         v.corner_bottom_right = '0;
         v.corner_top_right    = '0;
         v.triangles_valid     = 1'b0;
      end
      wrap_mesh = (row >= n) && (col + 1 >= n);
      v.last_vertex = wrap_mesh;
      if (wrap_mesh) begin
         restart_walk();
      end else if (col + 1 >= n) begin
         column_q       = '0;
         azim_phase_q   = '0;
         azim_rem_q     = '0;
         ring_q         = 9'(row + 1);
         vertex_count_q = vertex_count_q + 1'b1;
         elev_phase_q   = elev_phase_q + 16'(32768 / n);
         r = int'(elev_rem_q) + 32768 % n;
         if (r >= n) begin
            r = r - n;
            elev_phase_q = elev_phase_q + 1'b1;
         end
         elev_rem_q = 9'(r);
      end else begin
         column_q       = 8'(col + 1);
         vertex_count_q = vertex_count_q + 1'b1;
         azim_phase_q   = azim_phase_q + 16'(65536 / n);
         r = int'(azim_rem_q) + 65536 % n;
         if (r >= n) begin
            r = r - n;
            azim_phase_q = azim_phase_q + 1'b1;
         end
         azim_rem_q = 9'(r);
      end
      return v;
   endfunction

   function automatic void compare_field(input string name, input logic signed [63:0] e,
                                         input logic signed [63:0] a);
      if (e !== a) begin
         $error("%s: expected %0d, actual %0d", name, e, a);
         mismatches++;
      end
   endfunction

   function automatic void check_vertex(input vertex_type e, input vertex_type a);
      compare_field("pos_x", e.pos_x, a.pos_x);
      compare_field("pos_y", e.pos_y, a.pos_y);
      compare_field("pos_z", e.pos_z, a.pos_z);
      compare_field("vertex_index", e.vertex_index, a.vertex_index);
      compare_field("corner_bottom_left", e.corner_bottom_left, a.corner_bottom_left);
      compare_field("corner_bottom_right", e.corner_bottom_right, a.corner_bottom_right);
      compare_field("corner_top_right", e.corner_top_right, a.corner_top_right);
      compare_field("triangles_valid", e.triangles_valid, a.triangles_valid);
      compare_field("last_vertex", e.last_vertex, a.last_vertex);
   endfunction

   // Request side: bursts of beats with random gaps; a stalled beat holds.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sent_beat = beat_q.pop_front();
            predicted = next_vertex(sent_beat.restart);
            vertex_q.insert(vertex_q.size(), sent_beat.typed ? sent_beat.exp : predicted);
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = (quiet_sender || $urandom_range(0, 3) == 0) ? 0
                          : $urandom_range(1, 8);
            end
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (beat_q.size() > 0) begin
               req_valid   <= 1'b1;
               req_restart <= beat_q[0].restart;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response side: stall pattern and comparison.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed = '{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_vertex_index,
                      rsp_corner_bottom_left, rsp_corner_bottom_right,
                      rsp_corner_top_right, rsp_triangles_valid, rsp_last_vertex};
         if (vertex_q.size() == 0) begin
            $error("Response beat arrived with no vertex expected.");
            mismatches++;
         end else begin
            awaited = vertex_q.pop_front();
            check_vertex(awaited, observed);
         end
      end
      rsp_stall <= !reset && stall_pattern[stall_pos];
      stall_pos <= stall_pos + 1'b1;
   end

   task automatic wait_idle();
      do @(posedge clock); while (beat_q.size() != 0 || vertex_q.size() != 0);
      repeat (VERTEX_LATENCY) @(posedge clock);
   endtask

   task automatic write_resolution(input logic [CSR_W-1:0] value);
      wait_idle();
      csr_valid      <= 1'b1;
      csr_resolution <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_resolution(value);
   endtask

   function automatic logic [15:0] pick_stall_pattern();
      if ($urandom_range(0, 2) == 0) return '0;
      return 16'($urandom) & 16'hFFFE;
   endfunction

   initial begin
      int phase, k;
      logic [CSR_W-1:0] res_pick;
      apply_resolution(CSR_W'(RES_RESET));
      stall_pattern = pick_stall_pattern();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == STIM_CSR) begin
            write_resolution(DIRECTED[i].value);
         end else begin
            queue_beat(DIRECTED[i].value[0], DIRECTED[i].typed, DIRECTED[i].exp);
         end
      end

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: res_pick = 9'd256;
            1: res_pick = 9'd3;
            default: res_pick = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                            : 9'($urandom_range(3, 9));
         endcase
         write_resolution(res_pick);
         quiet_sender  = ($urandom_range(0, 3) == 0);
         stall_pattern = pick_stall_pattern();
         for (k = 0; k < PHASE_BEATS; k++) begin
            if (k == PHASE_BEATS / 2 && phase % 3 == 2) wait_idle();
            queue_beat(($urandom_range(0, 39) == 0), 1'b0, NO_VERTEX);
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
